// ----- rtl/core/tlbpt_pkg.sv -----
// shared constants and controller/datapath signal groups of the tlb page table translator
package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BYTES  = 256;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;

  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int IDX_W   = $clog2(TLB_ENTRIES);
  localparam int AGE_W   = 16;
  localparam int CNT_W   = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // victim search tree: first level over groups, second level over group winners
  localparam int TLB_GROUP = 4;
  localparam int NGROUPS   = (TLB_ENTRIES + TLB_GROUP - 1) / TLB_GROUP;

  typedef struct packed {
    logic accept;       // capture word, run tlb compare, age entries, read page table
    logic look;         // register group maxima and page table valid bit
    logic commit_hit;   // finish a hit into the output register
    logic commit_fill;  // refill victim, update page table, finish into output register
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

endpackage

// ----- rtl/core/tlbpt_ctrl.sv -----
// controller state machine of the tlb page table translator
module tlbpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tlbpt_pkg::status_t status_i,
  output tlbpt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        if (!status_i.hit) begin
          state_d = ST_FILL;
        end else if (out_free) begin
          cmd_o.commit_hit = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          cmd_o.commit_fill = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/tlbpt_datapath.sv -----
// tlb entries, page table memory, counters and output register of the translator
module tlbpt_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tlbpt_pkg::cmd_t                   cmd_i,
  output tlbpt_pkg::status_t                status_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0]      logical_address_i,
  output logic [tlbpt_pkg::ADDR_W-1:0]      physical_address_o,
  output logic                              tlb_hit_o,
  output logic                              page_fault_o,
  output logic [tlbpt_pkg::CNT_W-1:0]       hit_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]       fault_total_o
);

  // tlb
  logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_valid_q;
  logic [tlbpt_pkg::AGE_W-1:0]       tlb_age_q   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::PAGE_W-1:0]      tlb_page_q  [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0]     tlb_frame_q [tlbpt_pkg::TLB_ENTRIES];

  // page table
  logic [tlbpt_pkg::PAGE_COUNT-1:0] map_valid_q;
  logic [tlbpt_pkg::FRAME_W-1:0]    map_mem [tlbpt_pkg::PAGE_COUNT];
  logic [tlbpt_pkg::FRAME_W-1:0]    map_rdata_q;
  logic                             map_hit_q;

  // per-word registers
  logic [tlbpt_pkg::PAGE_W-1:0] page_q;
  logic [tlbpt_pkg::OFF_W-1:0]  offset_q;
  logic                         hit_q;
  logic [tlbpt_pkg::IDX_W-1:0]  hit_idx_q;

  logic [tlbpt_pkg::IDX_W-1:0]  grp_idx_q [tlbpt_pkg::NGROUPS];
  logic [tlbpt_pkg::AGE_W-1:0]  grp_age_q [tlbpt_pkg::NGROUPS];
  logic [tlbpt_pkg::IDX_W-1:0]  grp_idx_d [tlbpt_pkg::NGROUPS];
  logic [tlbpt_pkg::AGE_W-1:0]  grp_age_d [tlbpt_pkg::NGROUPS];

  logic [tlbpt_pkg::FRAME_W-1:0] next_free_q, next_free_d;
  logic [tlbpt_pkg::CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [tlbpt_pkg::CNT_W-1:0]   fault_cnt_q, fault_cnt_d;

  logic [tlbpt_pkg::ADDR_W-1:0]  addr_shift;
  logic [tlbpt_pkg::PAGE_W-1:0]  in_page;
  logic                          look_hit;
  logic [tlbpt_pkg::IDX_W-1:0]   look_idx;
  logic [tlbpt_pkg::IDX_W-1:0]   victim_idx;
  logic [tlbpt_pkg::FRAME_W-1:0] frame_sel;
  logic                          fault_now;

  // output register
  logic [tlbpt_pkg::ADDR_W-1:0] phys_q;
  logic                         out_hit_q;
  logic                         out_fault_q;
  logic [tlbpt_pkg::CNT_W-1:0]  out_hit_tot_q;
  logic [tlbpt_pkg::CNT_W-1:0]  out_fault_tot_q;

  // page number modulo table size
  assign addr_shift = logical_address_i >> tlbpt_pkg::OFF_W;
  assign in_page    = tlbpt_pkg::PAGE_W'(addr_shift);

  // fully associative compare, lowest matching entry wins
  always_comb begin
    look_hit = 1'b0;
    look_idx = '0;
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      if (!look_hit && tlb_valid_q[i] && (tlb_page_q[i] == in_page)) begin
        look_hit = 1'b1;
        look_idx = tlbpt_pkg::IDX_W'(i);
      end
    end
  end

  // first level of the oldest-entry search, strict compare keeps lowest index
  always_comb begin
    for (int g = 0; g < tlbpt_pkg::NGROUPS; g++) begin
      grp_idx_d[g] = tlbpt_pkg::IDX_W'(g * tlbpt_pkg::TLB_GROUP);
      grp_age_d[g] = tlb_age_q[g * tlbpt_pkg::TLB_GROUP];
      for (int k = 1; k < tlbpt_pkg::TLB_GROUP; k++) begin
        if ((g * tlbpt_pkg::TLB_GROUP + k) < tlbpt_pkg::TLB_ENTRIES) begin
          if (tlb_age_q[g * tlbpt_pkg::TLB_GROUP + k] > grp_age_d[g]) begin
            grp_idx_d[g] = tlbpt_pkg::IDX_W'(g * tlbpt_pkg::TLB_GROUP + k);
            grp_age_d[g] = tlb_age_q[g * tlbpt_pkg::TLB_GROUP + k];
          end
        end
      end
    end
  end

  // second level over group winners
  always_comb begin
    logic [tlbpt_pkg::AGE_W-1:0] best_age;
    best_age   = grp_age_q[0];
    victim_idx = grp_idx_q[0];
    for (int g = 1; g < tlbpt_pkg::NGROUPS; g++) begin
      if (grp_age_q[g] > best_age) begin
        best_age   = grp_age_q[g];
        victim_idx = grp_idx_q[g];
      end
    end
  end

  // result frame and counter updates
  always_comb begin
    fault_now = !hit_q && !map_hit_q;
    if (hit_q) begin
      frame_sel = tlb_frame_q[hit_idx_q];
    end else if (map_hit_q) begin
      frame_sel = map_rdata_q;
    end else begin
      frame_sel = next_free_q;
    end
    hit_cnt_d   = hit_cnt_q;
    fault_cnt_d = fault_cnt_q;
    next_free_d = next_free_q;
    if (cmd_i.commit_hit && (hit_cnt_q != tlbpt_pkg::CNT_MAX)) begin
      hit_cnt_d = hit_cnt_q + 1'b1;
    end
    if (cmd_i.commit_fill && fault_now) begin
      if (fault_cnt_q != tlbpt_pkg::CNT_MAX) begin
        fault_cnt_d = fault_cnt_q + 1'b1;
      end
      if (next_free_q == tlbpt_pkg::FRAME_W'(tlbpt_pkg::FRAME_COUNT - 1)) begin
        next_free_d = '0;
      end else begin
        next_free_d = next_free_q + 1'b1;
      end
    end
  end

  // control state: valid bits, ages, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
      map_valid_q <= '0;
      for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
        tlb_age_q[i] <= '0;
      end
      next_free_q <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
          if (look_hit && (look_idx == tlbpt_pkg::IDX_W'(i))) begin
            tlb_age_q[i] <= '0;
          end else if (tlb_age_q[i] != tlbpt_pkg::AGE_MAX) begin
            tlb_age_q[i] <= tlb_age_q[i] + 1'b1;
          end
        end
      end
      if (cmd_i.commit_fill) begin
        tlb_valid_q[victim_idx] <= 1'b1;
        tlb_age_q[victim_idx]   <= '0;
        if (fault_now) begin
          map_valid_q[page_q] <= 1'b1;
        end
      end
      next_free_q <= next_free_d;
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
    end
  end

  // page table frames, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      map_rdata_q <= map_mem[in_page];
    end
    if (cmd_i.commit_fill && fault_now) begin
      map_mem[page_q] <= next_free_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q    <= in_page;
      offset_q  <= logical_address_i[tlbpt_pkg::OFF_W-1:0];
      hit_q     <= look_hit;
      hit_idx_q <= look_idx;
    end
    if (cmd_i.look) begin
      map_hit_q <= map_valid_q[page_q];
      for (int g = 0; g < tlbpt_pkg::NGROUPS; g++) begin
        grp_idx_q[g] <= grp_idx_d[g];
        grp_age_q[g] <= grp_age_d[g];
      end
    end
    if (cmd_i.commit_fill) begin
      tlb_page_q[victim_idx]  <= page_q;
      tlb_frame_q[victim_idx] <= frame_sel;
    end
    if (cmd_i.commit_hit || cmd_i.commit_fill) begin
      phys_q          <= tlbpt_pkg::ADDR_W'({frame_sel, offset_q});
      out_hit_q       <= hit_q;
      out_fault_q     <= fault_now;
      out_hit_tot_q   <= hit_cnt_d;
      out_fault_tot_q <= fault_cnt_d;
    end
  end

  assign status_o.hit       = hit_q;
  assign physical_address_o = phys_q;
  assign tlb_hit_o          = out_hit_q;
  assign page_fault_o       = out_fault_q;
  assign hit_total_o        = out_hit_tot_q;
  assign fault_total_o      = out_fault_tot_q;

endmodule

// ----- rtl/core/tlb_page_table_translator.sv -----
// top level of the tlb and demand-paging address translator
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    logical_address_i
//   out      source     out_valid_o / out_stall_i  physical_address_o, tlb_hit_o,
//                                                  page_fault_o, hit_total_o, fault_total_o
//
// one word at a time: accept compares all tlb entries, ages them and reads the page table,
// the look state registers the page table valid bit and the first level of the oldest-entry
// search and finishes a hit once the output register is free, the fill state refills on a miss
// reset clears tlb valid bits, ages, page table valid bits and counters at once
// a result held by out_stall_i waits in the output register; the next word is taken
// meanwhile and finishes once the output register frees up
module tlb_page_table_translator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0] logical_address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlbpt_pkg::ADDR_W-1:0] physical_address_o,
  output logic                         tlb_hit_o,
  output logic                         page_fault_o,
  output logic [tlbpt_pkg::CNT_W-1:0]  hit_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]  fault_total_o
);

  // command and status between sequencer and datapath
  tlbpt_pkg::cmd_t    cmd;
  tlbpt_pkg::status_t status;

  tlbpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // tlb, page table, counters and output register
  tlbpt_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .logical_address_i  (logical_address_i),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the tlb page table translator: scoreboard class, drivers, checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 4;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int HOLD_CYCLES      = 300;
  localparam int TAIL_WORDS       = 24;
  localparam int DRAIN_CYCLES     = 10;
  localparam int MAX_PRINTED      = 100;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // one translation as the block should report it
  typedef struct packed {
    bit [tlbpt_pkg::ADDR_W-1:0] logical_address;
    bit [tlbpt_pkg::ADDR_W-1:0] physical_address;
    bit                         tlb_hit;
    bit                         page_fault;
    bit [tlbpt_pkg::CNT_W-1:0]  hit_total;
    bit [tlbpt_pkg::CNT_W-1:0]  fault_total;
  } translation_t;

  // shadow tlb and page table plus the queue of translations still owed by the block
  class xlate_scoreboard;
    bit                          tlb_valid [tlbpt_pkg::TLB_ENTRIES];
    bit [tlbpt_pkg::PAGE_W-1:0]  tlb_page  [tlbpt_pkg::TLB_ENTRIES];
    bit [tlbpt_pkg::FRAME_W-1:0] tlb_frame [tlbpt_pkg::TLB_ENTRIES];
    bit [tlbpt_pkg::AGE_W-1:0]   tlb_age   [tlbpt_pkg::TLB_ENTRIES];
    bit                          map_valid [tlbpt_pkg::PAGE_COUNT];
    bit [tlbpt_pkg::FRAME_W-1:0] map_frame [tlbpt_pkg::PAGE_COUNT];
    bit [tlbpt_pkg::FRAME_W:0]   next_frame;
    bit [tlbpt_pkg::CNT_W-1:0]   hit_count;
    bit [tlbpt_pkg::CNT_W-1:0]   fault_count;
    translation_t                expected_xlates [$];
    int unsigned                 mismatches;

    function translation_t translate(bit [tlbpt_pkg::ADDR_W-1:0] addr);
      translation_t                res;
      bit [tlbpt_pkg::PAGE_W-1:0]  page;
      bit [tlbpt_pkg::OFF_W-1:0]   offset;
      bit [tlbpt_pkg::FRAME_W-1:0] frame;
      int                          i;
      int                          victim;
      res = '0;
      res.logical_address = addr;
      page   = tlbpt_pkg::PAGE_W'((addr / tlbpt_pkg::PAGE_BYTES) % tlbpt_pkg::PAGE_COUNT);
      offset = tlbpt_pkg::OFF_W'(addr % tlbpt_pkg::PAGE_BYTES);
      frame  = '0;
      // first matching entry is used, everything else ages
      for (i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
        if (!res.tlb_hit && tlb_valid[i] && tlb_page[i] == page) begin
          res.tlb_hit = 1'b1;
          frame = tlb_frame[i];
          tlb_age[i] = '0;
        end else if (tlb_age[i] != tlbpt_pkg::AGE_MAX) begin
          tlb_age[i]++;
        end
      end
      if (res.tlb_hit) begin
        if (hit_count != tlbpt_pkg::CNT_MAX) hit_count++;
      end else begin
        if (map_valid[page]) begin
          frame = map_frame[page];
        end else begin
          // demand paging: next frame in order, wraps after the last one
          res.page_fault = 1'b1;
          if (fault_count != tlbpt_pkg::CNT_MAX) fault_count++;
          frame = tlbpt_pkg::FRAME_W'(next_frame);
          map_valid[page] = 1'b1;
          map_frame[page] = frame;
          if (next_frame + 1 >= tlbpt_pkg::FRAME_COUNT) next_frame = '0;
          else next_frame++;
        end
        // oldest entry is refilled, lowest index on ties
        victim = 0;
        for (i = 1; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
          if (tlb_age[i] > tlb_age[victim]) victim = i;
        end
        tlb_valid[victim] = 1'b1;
        tlb_page[victim]  = page;
        tlb_frame[victim] = frame;
        tlb_age[victim]   = '0;
      end
      res.physical_address = tlbpt_pkg::ADDR_W'(int'(frame) * tlbpt_pkg::PAGE_BYTES
                                                + int'(offset));
      res.hit_total   = hit_count;
      res.fault_total = fault_count;
      return res;
    endfunction

    function void note_address(bit [tlbpt_pkg::ADDR_W-1:0] addr);
      expected_xlates.push_back(translate(addr));
    endfunction

    function int unsigned pending();
      return expected_xlates.size();
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(input logic [tlbpt_pkg::ADDR_W-1:0] pa, input logic hit,
                      input logic fault, input logic [tlbpt_pkg::CNT_W-1:0] hits,
                      input logic [tlbpt_pkg::CNT_W-1:0] faults);
      translation_t want;
      if (expected_xlates.size() == 0) begin
        report_mismatch($sformatf("result pa %h with no translation pending", pa));
        return;
      end
      want = expected_xlates.pop_front();
      if (pa !== want.physical_address)
        report_mismatch($sformatf("la %h physical_address got %h exp %h",
                                  want.logical_address, pa, want.physical_address));
      if (hit !== want.tlb_hit)
        report_mismatch($sformatf("la %h tlb_hit got %b exp %b",
                                  want.logical_address, hit, want.tlb_hit));
      if (fault !== want.page_fault)
        report_mismatch($sformatf("la %h page_fault got %b exp %b",
                                  want.logical_address, fault, want.page_fault));
      if (hits !== want.hit_total)
        report_mismatch($sformatf("la %h hit_total got %0d exp %0d",
                                  want.logical_address, hits, want.hit_total));
      if (faults !== want.fault_total)
        report_mismatch($sformatf("la %h fault_total got %0d exp %0d",
                                  want.logical_address, faults, want.fault_total));
    endtask
  endclass

  // block ports, all inputs known from time zero
  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [tlbpt_pkg::ADDR_W-1:0] logical_address_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [tlbpt_pkg::ADDR_W-1:0] physical_address_o;
  logic                         tlb_hit_o;
  logic                         page_fault_o;
  logic [tlbpt_pkg::CNT_W-1:0]  hit_total_o;
  logic [tlbpt_pkg::CNT_W-1:0]  fault_total_o;

  xlate_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     holds_requested = 0;
  int unsigned     cycle_count = 0;

  tlb_page_table_translator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // run guard, a correct run stays far below the limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // both channels sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) sb.note_address(logical_address_i);
      if (out_valid_o === 1'b1 && !out_stall_i)
        sb.check_result(physical_address_o, tlb_hit_o, page_fault_o,
                        hit_total_o, fault_total_o);
    end
  end

  // receiver: random stall at the falling edge, or a long hold-off when asked
  initial begin
    int unsigned holds_done;
    int unsigned k;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_requested) begin
        holds_done++;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one word, entered and left at a falling edge; valid stays up until taken
  task automatic send_address(input bit [tlbpt_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    logical_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // bursts: small working sets for hits and lru thrash, page sweeps, plain random
  task automatic run_mixed_traffic(input int unsigned count);
    int unsigned                sent;
    int unsigned                len;
    int unsigned                kind;
    int unsigned                nset;
    int unsigned                i;
    bit [tlbpt_pkg::PAGE_W-1:0] ws [20];
    bit [tlbpt_pkg::PAGE_W-1:0] base;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        // set sizes straddle the tlb size
        nset = $urandom_range(20, 1);
        for (i = 0; i < nset; i++) ws[i] = tlbpt_pkg::PAGE_W'($urandom);
        len = $urandom_range(40, 10);
        for (i = 0; i < len; i++)
          send_address({ws[$urandom_range(nset - 1)], tlbpt_pkg::OFF_W'($urandom)});
      end else if (kind < 70) begin
        base = tlbpt_pkg::PAGE_W'($urandom);
        len  = $urandom_range(40, 8);
        for (i = 0; i < len; i++)
          send_address({base + tlbpt_pkg::PAGE_W'(i), tlbpt_pkg::OFF_W'($urandom)});
      end else begin
        len = $urandom_range(20, 5);
        for (i = 0; i < len; i++) send_address(tlbpt_pkg::ADDR_W'($urandom));
      end
      sent += len;
    end
  endtask

  initial begin
    bit [tlbpt_pkg::ADDR_W-1:0] corner [9];
    int unsigned                k;
    corner = '{16'h0000, 16'h00ff, 16'hffff, 16'hff00, 16'h8000,
               16'h7fff, 16'h5555, 16'haaaa, 16'h0000};
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // phase one: sender idles a little, receiver stalls most of the time
    send_idle_pct = 20;
    recv_idle_pct = 88;
    // address extremes, first faults, hits on pages just mapped
    foreach (corner[c]) send_address(corner[c]);
    // sixteen fresh pages push every earlier entry out of the tlb
    for (k = 0; k < tlbpt_pkg::TLB_ENTRIES; k++)
      send_address({tlbpt_pkg::PAGE_W'(8'h10 + k), tlbpt_pkg::OFF_W'($urandom)});
    // evicted page comes back from the page table without a fault
    send_address(16'hff80);
    run_mixed_traffic(RANDOM_PER_PHASE);

    // phase two: roles swapped
    send_idle_pct = 88;
    recv_idle_pct = 20;
    run_mixed_traffic(RANDOM_PER_PHASE);

    // phase three: no idling, starting with a long receiver hold-off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_requested++;
    run_mixed_traffic(RANDOM_PER_PHASE);
    // walk every page so the whole page table gets mapped and the free frame pointer wraps
    for (k = 0; k < tlbpt_pkg::PAGE_COUNT; k++)
      send_address({tlbpt_pkg::PAGE_W'(k), tlbpt_pkg::OFF_W'($urandom)});

    // random tail with every page mapped, so no further page faults
    for (k = 0; k < TAIL_WORDS; k++) send_address(tlbpt_pkg::ADDR_W'($urandom));
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_ctrl.sv
rtl/core/tlbpt_datapath.sv
rtl/core/tlb_page_table_translator.sv
dv/tb_top.sv
